// File: rtl/wpts_pkg.sv
// ----------------------------------------------------------------------------
// wpts_pkg
// Shared types and constants for the wrapped palette texture sampler.
// ----------------------------------------------------------------------------
package wpts_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 16;   // integer part of a Q16.16 coordinate
  localparam int SIDE_W     = 9;    // texture side, 0..MAX_SIDE
  localparam int IDX_W      = 8;    // texel index / palette address
  localparam int TEXEL_AW   = 16;   // texel store address
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Wrap unit: restoring remainder, four bits per stage
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = COORD_W / BITS_PER_STAGE;
  localparam int WRAP_LAT       = DIV_STAGES + 2;

  localparam int TEXEL_DEPTH   = 1 << TEXEL_AW;
  localparam int PALETTE_DEPTH = 1 << IDX_W;

  localparam logic [SIDE_W-1:0]  MAX_SIDE   = SIDE_W'(256);
  localparam logic [COLOR_W-1:0] GREY_ALPHA = 32'hFF00_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_TEXEL   = 2'd0,
    CMD_WRITE_PALETTE = 2'd1,
    CMD_SAMPLE        = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXTURE_WIDTH  = 2'd0,
    REG_TEXTURE_HEIGHT = 2'd1,
    REG_PALETTE_ENABLE = 2'd2
  } reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic [15:0]        write_address;
    logic [31:0]        write_data;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   texel_index;
    logic [COLOR_W-1:0] argb_color;
  } out_item_t;

  // Per-stage control that travels alongside the datapath
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [15:0]      write_address;
    logic [31:0]      write_data;
  } ctl_t;

endpackage

// File: rtl/wpts_wrap.sv
// ----------------------------------------------------------------------------
// wpts_wrap
// Pipelined true modulo of a signed integer coordinate into [0, side).
// ----------------------------------------------------------------------------
module wpts_wrap (
  input  logic                                clk_i,
  input  logic signed [wpts_pkg::COORD_W-1:0] coord_i,
  input  logic [wpts_pkg::SIDE_W-1:0]         side_i,
  output logic [wpts_pkg::IDX_W-1:0]          wrapped_o
);

  localparam int CW = wpts_pkg::COORD_W;
  localparam int SW = wpts_pkg::SIDE_W;
  localparam int NS = wpts_pkg::DIV_STAGES;
  localparam int BS = wpts_pkg::BITS_PER_STAGE;

  logic [CW-1:0] mag_q [NS+1];
  logic          neg_q [NS+1];
  logic [SW-1:0] rem_q [NS+1];
  logic [SW-1:0] rem_d [NS];
  logic [wpts_pkg::IDX_W-1:0] wrapped_q;

  // Split into sign and magnitude; the most negative value fits unsigned
  always_ff @(posedge clk_i) begin
    mag_q[0] <= coord_i[CW-1] ? CW'(-coord_i) : CW'(coord_i);
    neg_q[0] <= coord_i[CW-1];
    rem_q[0] <= '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [SW:0]   trial;
    logic [SW-1:0] part;

    always_comb begin
      part  = rem_q[s];
      trial = '0;
      for (int k = 0; k < BS; k++) begin
        trial = {part, mag_q[s][CW-1-s*BS-k]};
        if (trial >= {1'b0, side_i}) begin
          trial = trial - {1'b0, side_i};
        end
        part = trial[SW-1:0];
      end
      rem_d[s] = part;
    end

    always_ff @(posedge clk_i) begin
      mag_q[s+1] <= mag_q[s];
      neg_q[s+1] <= neg_q[s];
      rem_q[s+1] <= rem_d[s];
    end
  end

  // Fold a negative remainder back into range
  always_ff @(posedge clk_i) begin
    if (neg_q[NS] && (rem_q[NS] != '0)) begin
      wrapped_q <= wpts_pkg::IDX_W'(side_i - rem_q[NS]);
    end else begin
      wrapped_q <= wpts_pkg::IDX_W'(rem_q[NS]);
    end
  end

  assign wrapped_o = wrapped_q;

endmodule

// File: rtl/wrapped_palette_texture_sampler.sv
// ----------------------------------------------------------------------------
// wrapped_palette_texture_sampler
// Nearest-neighbor sampler for an 8-bit indexed texture with ARGB palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken at each rising edge with start high
//   and busy low. busy never rises, so one transaction per clock is taken.
//   cmd selects texel write, palette write or sample; cmd 3 is dropped.
//   Result channel: each sample gives one result, shown on result_o for a
//   single cycle while result_valid_o is high. Writes give no result.
//   Pipeline: a sample result passes through 11 stages (input register,
//   6-stage wrap unit, address, texel read, palette read, output). Every
//   stage advances on each clock, so one transaction per cycle is taken.
//   Writes land in the stores at the same stage where samples read, so every
//   sample sees exactly the writes taken before it.
//   Configuration: cfg_we_i writes register cfg_index_i (0 width, 1 height,
//   2 palette enable) from cfg_data_i; write only while the pipeline is empty.
//   Reset: zeroes the config registers and empties the pipeline; store
//   contents are undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module wrapped_palette_texture_sampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  wpts_pkg::in_item_t                  item_i,
  output logic                                result_valid_o,
  output wpts_pkg::out_item_t                 result_o,
  input  logic                                cfg_we_i,
  input  logic [wpts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wpts_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SW     = wpts_pkg::SIDE_W;
  localparam int IW     = wpts_pkg::IDX_W;
  localparam int AW     = wpts_pkg::TEXEL_AW;
  localparam int CW     = wpts_pkg::COORD_W;
  // Control stages: input reg, wrap stages, address, texel read, palette read
  localparam int ADDR_S = wpts_pkg::WRAP_LAT + 1;
  localparam int TEX_S  = ADDR_S + 1;
  localparam int PAL_S  = TEX_S + 1;
  localparam int NSTG   = PAL_S + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SW-1:0] width_q, height_q;
  logic          pal_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      pal_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wpts_pkg::REG_TEXTURE_WIDTH:  width_q  <= cfg_data_i;
        wpts_pkg::REG_TEXTURE_HEIGHT: height_q <= cfg_data_i;
        wpts_pkg::REG_PALETTE_ENABLE: pal_en_q <= cfg_data_i[0];
        default: ;  // unknown index: drop
      endcase
    end
  end

  // Saturate sides to the largest supported texture
  logic [SW-1:0] w_side, h_side;
  logic          zero_side;

  assign w_side    = (width_q  > wpts_pkg::MAX_SIDE) ? wpts_pkg::MAX_SIDE : width_q;
  assign h_side    = (height_q > wpts_pkg::MAX_SIDE) ? wpts_pkg::MAX_SIDE : height_q;
  assign zero_side = (w_side == '0) || (h_side == '0);

  // --------------------------------------------------------------------------
  // Control pipeline: valid bits reset, payload does not
  // --------------------------------------------------------------------------
  logic             valid_q [NSTG];
  wpts_pkg::ctl_t   ctl_q   [NSTG];
  logic signed [CW-1:0] u_int_q, v_int_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      valid_q[0] <= start && !busy;
      for (int i = 1; i < NSTG; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0].cmd           <= item_i.cmd;
    ctl_q[0].write_address <= item_i.write_address;
    ctl_q[0].write_data    <= item_i.write_data;
    // Floor of Q16.16: keep the integer half
    u_int_q <= item_i.u_coord[31:16];
    v_int_q <= item_i.v_coord[31:16];
    for (int i = 1; i < NSTG; i++) begin
      ctl_q[i] <= ctl_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Wrap coordinates into the texture
  // --------------------------------------------------------------------------
  logic [IW-1:0] x_wrap, y_wrap;

  wpts_wrap u_wrap_x (
    .clk_i     (clk_i),
    .coord_i   (u_int_q),
    .side_i    (w_side),
    .wrapped_o (x_wrap)
  );

  wpts_wrap u_wrap_y (
    .clk_i     (clk_i),
    .coord_i   (v_int_q),
    .side_i    (h_side),
    .wrapped_o (y_wrap)
  );

  // Texel address y*w + x, wrapped to the store size
  logic [AW:0]   addr_sum;
  logic [AW-1:0] addr_q;

  assign addr_sum = (AW+1)'(y_wrap) * (AW+1)'(w_side) + (AW+1)'(x_wrap);

  always_ff @(posedge clk_i) begin
    addr_q <= addr_sum[AW-1:0];
  end

  // --------------------------------------------------------------------------
  // Texel store: writes and sample reads share one stage to keep order
  // --------------------------------------------------------------------------
  logic [IW-1:0] texel_mem [wpts_pkg::TEXEL_DEPTH];
  logic [IW-1:0] tex_rd_q;
  logic          tex_we;

  assign tex_we = valid_q[ADDR_S] && (ctl_q[ADDR_S].cmd == wpts_pkg::CMD_WRITE_TEXEL);

  always_ff @(posedge clk_i) begin
    if (tex_we) begin
      texel_mem[ctl_q[ADDR_S].write_address] <= ctl_q[ADDR_S].write_data[IW-1:0];
    end
    tex_rd_q <= texel_mem[addr_q];
  end

  // --------------------------------------------------------------------------
  // Palette store
  // --------------------------------------------------------------------------
  logic [wpts_pkg::COLOR_W-1:0] palette_mem [wpts_pkg::PALETTE_DEPTH];
  logic [wpts_pkg::COLOR_W-1:0] pal_rd_q;
  logic [IW-1:0]                idx, idx_q;
  logic                         pal_we;

  // Degenerate texture: index zero
  assign idx    = zero_side ? '0 : tex_rd_q;
  assign pal_we = valid_q[TEX_S] && (ctl_q[TEX_S].cmd == wpts_pkg::CMD_WRITE_PALETTE);

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      palette_mem[ctl_q[TEX_S].write_address[IW-1:0]] <= ctl_q[TEX_S].write_data;
    end
    pal_rd_q <= palette_mem[idx];
    idx_q    <= idx;
  end

  // --------------------------------------------------------------------------
  // Output register: palette color or opaque grey
  // --------------------------------------------------------------------------
  logic                result_valid_q;
  wpts_pkg::out_item_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= valid_q[PAL_S] && (ctl_q[PAL_S].cmd == wpts_pkg::CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.texel_index <= idx_q;
    if (pal_en_q) begin
      result_q.argb_color <= pal_rd_q;
    end else begin
      result_q.argb_color <= wpts_pkg::GREY_ALPHA | {8'h00, idx_q, idx_q, idx_q};
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
